### rtl/tfss_pkg.sv
// shared types and constants for the tolerant float signature scanner
`default_nettype none
package tfss_pkg;

    localparam int ADDR_W    = 47;
    localparam int SIG_WORDS = 12;
    localparam int SIG_REGS  = 6;
    localparam int CFG_IDX_W = 4;
    localparam int CNT_W     = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_PAIR_0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_PAIR_1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_LEN    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_CAP    = 4'd7;

    localparam logic [CNT_W-1:0] DEFAULT_CAP = 16'd512;

    // |b| above 1e-6f selects |b| as the divisor, else 1.0f
    localparam logic [30:0] TINY_MAG = 31'h358637BD;
    localparam logic [23:0] ONE_SIG  = 24'h800000;
    localparam logic [7:0]  ONE_EXP  = 8'd127;

    // midpoint between 0.0005f and its predecessor is MID_SIG * 2^-MID_SHIFT
    localparam logic [24:0] MID_SIG   = 25'h10624DD;
    localparam int          MID_SHIFT = 35;

    typedef struct packed {
        logic [31:0]       word_bits;
        logic [ADDR_W-1:0] word_addr;
        logic              window_restart;
        logic              scan_start;
    } word_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] hit_addr;
        logic [CNT_W-1:0]  hit_number;
        logic              cap_reached;
    } hit_item_t;

endpackage
`default_nettype wire

### rtl/tfss_front.sv
// input side: accepts word beats into a two-entry queue for the back end
`default_nettype none
module tfss_front
    import tfss_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       word_valid,
    output logic            word_stall,
    input  wire word_item_t word_item,
    output logic            q_valid,
    output word_item_t      q_item,
    input  wire logic       q_pop
);

    word_item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    assign word_stall = (count_reg == 2'd2);
    assign push       = word_valid && !word_stall;
    assign q_valid    = (count_reg != 2'd0);
    assign q_item     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= word_item;
        end
    end

endmodule
`default_nettype wire

### rtl/tfss_cmp.sv
// five-stage tolerant float compare: round(|a-b|)/m against 0.0005f, exact
`default_nettype none
module tfss_cmp
    import tfss_pkg::*;
#(
    parameter int TAG_W = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    input  wire logic [TAG_W-1:0] req_tag,
    input  wire logic [31:0]      req_a,
    input  wire logic [31:0]      req_b,
    output logic                  rsp_valid,
    output logic [TAG_W-1:0]      rsp_tag,
    output logic                  rsp_match
);

    // stage 1: unpack, order magnitudes, align smaller operand
    logic             s1_vld_reg;
    logic [TAG_W-1:0] s1_tag_reg;
    logic             s1_spec_reg, s1_sub_reg;
    logic [26:0]      s1_xa_reg, s1_ya_reg;
    logic [7:0]       s1_ex_reg, s1_em_reg;
    logic [23:0]      s1_m_reg;

    logic [26:0] xa_next, ya_next;
    logic [7:0]  ex_next, em_next;
    logic [23:0] m_next;
    logic        spec_next, sub_next;

    always_comb
    begin
        logic [30:0] abs_a, abs_b, mx, my;
        logic [23:0] sx, sy;
        logic [7:0]  ex_e, ey_e, dexp;
        logic [26:0] ya_full, ya_sh, lost_mask;
        logic        big;
        abs_a = req_a[30:0];
        abs_b = req_b[30:0];
        spec_next = (req_a[30:23] == 8'hFF) || (req_b[30:23] == 8'hFF);
        sub_next  = (req_a[31] == req_b[31]);
        if (abs_b > abs_a)
        begin
            mx = abs_b;
            my = abs_a;
        end
        else
        begin
            mx = abs_a;
            my = abs_b;
        end
        sx   = {mx[30:23] != 8'd0, mx[22:0]};
        sy   = {my[30:23] != 8'd0, my[22:0]};
        ex_e = (mx[30:23] == 8'd0) ? 8'd1 : mx[30:23];
        ey_e = (my[30:23] == 8'd0) ? 8'd1 : my[30:23];
        dexp = ex_e - ey_e;
        ya_full = {sy, 3'b000};
        if (dexp >= 8'd27)
        begin
            ya_sh     = 27'd0;
            lost_mask = '1;
        end
        else
        begin
            ya_sh     = ya_full >> dexp[4:0];
            lost_mask = (27'd1 << dexp[4:0]) - 27'd1;
        end
        xa_next = {sx, 3'b000};
        ya_next = {ya_sh[26:1], ya_sh[0] | (|(ya_full & lost_mask))};
        ex_next = ex_e;
        big     = (abs_b > TINY_MAG);
        m_next  = big ? {1'b1, req_b[22:0]} : ONE_SIG;
        em_next = big ? req_b[30:23] : ONE_EXP;
    end

    // stage 2: add or subtract magnitudes, scale the bound
    logic             s2_vld_reg;
    logic [TAG_W-1:0] s2_tag_reg;
    logic             s2_spec_reg;
    logic [27:0]      s2_r_reg;
    logic [7:0]       s2_ex_reg, s2_em_reg;
    logic [48:0]      s2_p_reg;
    logic [27:0]      r_next;
    logic [48:0]      p_next;

    assign r_next = s1_sub_reg ? ({1'b0, s1_xa_reg} - {1'b0, s1_ya_reg})
                               : ({1'b0, s1_xa_reg} + {1'b0, s1_ya_reg});
    assign p_next = 49'(MID_SIG) * 49'(s1_m_reg);

    // stage 3: normalize
    logic             s3_vld_reg;
    logic [TAG_W-1:0] s3_tag_reg;
    logic             s3_spec_reg;
    logic [26:0]      s3_rn_reg;
    logic [8:0]       s3_e_reg;
    logic [7:0]       s3_em_reg;
    logic [48:0]      s3_p_reg;
    logic [26:0]      rn_next;
    logic [8:0]       e_next;

    always_comb
    begin
        logic [4:0] lz;
        logic [7:0] lim, sh;
        lz = 5'd27;
        for (int i = 0; i < 27; i++)
        begin
            if (s2_r_reg[i])
            begin
                lz = 5'(26 - i);
            end
        end
        lim = s2_ex_reg - 8'd1;
        sh  = ({3'b000, lz} > lim) ? lim : {3'b000, lz};
        if (s2_r_reg[27])
        begin
            rn_next = {s2_r_reg[27:2], |s2_r_reg[1:0]};
            e_next  = {1'b0, s2_ex_reg} + 9'd1;
        end
        else
        begin
            rn_next = s2_r_reg[26:0] << sh[4:0];
            e_next  = {1'b0, s2_ex_reg} - {1'b0, sh};
        end
    end

    // stage 4: round to nearest even, exponent gap to the bound
    logic             s4_vld_reg;
    logic [TAG_W-1:0] s4_tag_reg;
    logic             s4_spec_reg;
    logic [24:0]      s4_d_reg;
    logic [10:0]      s4_s_reg;
    logic [48:0]      s4_p_reg;
    logic [24:0]      d_next;
    logic [10:0]      s_next;

    always_comb
    begin
        logic up;
        up     = s3_rn_reg[2] && ((|s3_rn_reg[1:0]) || s3_rn_reg[3]);
        d_next = {1'b0, s3_rn_reg[26:3]} + {24'd0, up};
        s_next = {2'b00, s3_e_reg} - {3'b000, s3_em_reg} + 11'(MID_SHIFT);
    end

    // stage 5: exact compare d <= mid * m
    logic match_next;

    always_comb
    begin
        logic [73:0] lhs;
        lhs = 74'(s4_d_reg) << s4_s_reg[5:0];
        if (s4_spec_reg)
        begin
            match_next = 1'b0;
        end
        else if (s4_s_reg[10])
        begin
            match_next = 1'b1;
        end
        else if (s4_s_reg >= 11'd49)
        begin
            match_next = (s4_d_reg == 25'd0);
        end
        else
        begin
            match_next = (lhs <= 74'(s4_p_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            rsp_valid  <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= req_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            rsp_valid  <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg  <= req_tag;
        s1_spec_reg <= spec_next;
        s1_sub_reg  <= sub_next;
        s1_xa_reg   <= xa_next;
        s1_ya_reg   <= ya_next;
        s1_ex_reg   <= ex_next;
        s1_em_reg   <= em_next;
        s1_m_reg    <= m_next;

        s2_tag_reg  <= s1_tag_reg;
        s2_spec_reg <= s1_spec_reg;
        s2_r_reg    <= r_next;
        s2_ex_reg   <= s1_ex_reg;
        s2_em_reg   <= s1_em_reg;
        s2_p_reg    <= p_next;

        s3_tag_reg  <= s2_tag_reg;
        s3_spec_reg <= s2_spec_reg;
        s3_rn_reg   <= rn_next;
        s3_e_reg    <= e_next;
        s3_em_reg   <= s2_em_reg;
        s3_p_reg    <= s2_p_reg;

        s4_tag_reg  <= s3_tag_reg;
        s4_spec_reg <= s3_spec_reg;
        s4_d_reg    <= d_next;
        s4_s_reg    <= s_next;
        s4_p_reg    <= s3_p_reg;

        rsp_tag     <= s4_tag_reg;
        rsp_match   <= match_next;
    end

endmodule
`default_nettype wire

### rtl/tfss_back.sv
// back end: issues signature compares, keeps the shift-and vector and hit count
`default_nettype none
module tfss_back
    import tfss_pkg::*;
#(
    parameter int MAX_SIG = 12,
    parameter int KW      = 4,
    parameter int LW      = 4
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire word_item_t                    q_item,
    output logic                               q_pop,
    input  wire logic [SIG_WORDS-1:0][31:0]    sig_words,
    input  wire logic [LW-1:0]                 sig_len,
    input  wire logic [CNT_W-1:0]              hit_cap,
    output logic                               req_valid,
    output logic [KW-1:0]                      req_tag,
    output logic [31:0]                        req_a,
    output logic [31:0]                        req_b,
    input  wire logic                          rsp_valid,
    input  wire logic [KW-1:0]                 rsp_tag,
    input  wire logic                          rsp_match,
    output logic                               hit_valid,
    input  wire logic                          hit_stall,
    output hit_item_t                          hit_item
);

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE} state_t;

    state_t            state_reg, state_next;
    logic [31:0]       word_reg, word_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [MAX_SIG-1:0] mvec_reg, mvec_next;
    logic [MAX_SIG-1:0] pm_reg, pm_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              hv_reg, hv_next;
    hit_item_t         hitem_reg, hitem_next;

    logic [KW-1:0]      last_k;
    logic [CNT_W-1:0]   cap;
    logic [MAX_SIG-1:0] pm_new;
    logic               hit_end;
    logic               can_report;
    logic               out_free;
    logic [31:0]        sig_sel;

    assign last_k    = KW'(sig_len - LW'(1));
    assign cap       = (hit_cap == '0) ? DEFAULT_CAP : hit_cap;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign req_valid = (state_reg == ST_ISSUE);
    assign req_tag   = k_reg;
    assign req_a     = word_reg;
    assign req_b     = sig_sel;
    assign hit_valid = hv_reg;
    assign hit_item  = hitem_reg;
    assign out_free  = !hv_reg || !hit_stall;

    // words past the register file read as zero
    always_comb
    begin
        sig_sel = 32'd0;
        for (int i = 0; i < SIG_WORDS; i++)
        begin
            if (int'(k_reg) == i)
            begin
                sig_sel = sig_words[i];
            end
        end
    end

    always_comb
    begin
        hit_end = 1'b0;
        for (int k = 0; k < MAX_SIG; k++)
        begin
            pm_new[k] = ((k == 0) ? 1'b1 : pm_reg[(k == 0) ? 0 : k - 1])
                        && mvec_reg[k] && (k < int'(sig_len));
            if (k == int'(sig_len) - 1)
            begin
                hit_end = pm_new[k];
            end
        end
        can_report = hit_end && (cnt_reg < cap);
    end

    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        addr_next  = addr_reg;
        k_next     = k_reg;
        mvec_next  = mvec_reg;
        pm_next    = pm_reg;
        cnt_next   = cnt_reg;
        hv_next    = hv_reg && hit_stall;
        hitem_next = hitem_reg;

        if (rsp_valid)
        begin
            for (int k = 0; k < MAX_SIG; k++)
            begin
                if (int'(rsp_tag) == k)
                begin
                    mvec_next[k] = rsp_match;
                end
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    word_next  = q_item.word_bits;
                    addr_next  = q_item.word_addr;
                    k_next     = '0;
                    mvec_next  = '0;
                    if (q_item.scan_start || q_item.window_restart)
                    begin
                        pm_next = '0;
                    end
                    if (q_item.scan_start)
                    begin
                        cnt_next = '0;
                    end
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                k_next = k_reg + KW'(1);
                if (k_reg == last_k)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (rsp_valid && rsp_tag == last_k)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!can_report || out_free)
                begin
                    pm_next = pm_new;
                    if (can_report)
                    begin
                        cnt_next               = cnt_reg + CNT_W'(1);
                        hv_next                = 1'b1;
                        hitem_next.hit_addr    = addr_reg
                                                 - {(ADDR_W-2)'(last_k), 2'b00};
                        hitem_next.hit_number  = cnt_reg + CNT_W'(1);
                        hitem_next.cap_reached = ((cnt_reg + CNT_W'(1)) >= cap);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            word_reg  <= '0;
            addr_reg  <= '0;
            k_reg     <= '0;
            mvec_reg  <= '0;
            pm_reg    <= '0;
            cnt_reg   <= '0;
            hv_reg    <= 1'b0;
            hitem_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
            addr_reg  <= addr_next;
            k_reg     <= k_next;
            mvec_reg  <= mvec_next;
            pm_reg    <= pm_next;
            cnt_reg   <= cnt_next;
            hv_reg    <= hv_next;
            hitem_reg <= hitem_next;
        end
    end

endmodule
`default_nettype wire

### rtl/tolerant_float_signature_scan.sv
// top level of the tolerant float signature scanner
//
// word beats (word_valid / word_stall / word_item) carry one 32-bit single
// word, its byte address and the restart flags. hit beats (hit_valid /
// hit_stall / hit_item) report the first address of each matching window.
// configuration goes through cfg_valid / cfg_ready / cfg_index / cfg_data,
// always ready; registers 0..5 hold signature word pairs, 6 the length,
// 7 the hit cap.
// each word is popped, then one compare per signature word is issued into
// the five-stage float compare unit, then the pipeline drains and the
// shift-and vector is updated. a two-entry input queue takes the next
// beats meanwhile.
// a hit leaves through a single output register once the last compare has
// returned; while hit_stall is high the hit holds, the back end waits with
// its next hit and the input queue fills, then word_stall rises.
// reset clears the queue, partial matches, the hit count and the output,
// and returns the signature to zero, length 1 and cap 512.
`default_nettype none
module tolerant_float_signature_scan
    import tfss_pkg::*;
#(
    parameter int MAX_SIG = 12
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 word_valid,
    output logic                      word_stall,
    input  wire word_item_t           word_item,
    output logic                      hit_valid,
    input  wire logic                 hit_stall,
    output hit_item_t                 hit_item,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data
);

    localparam int KW = (MAX_SIG > 1) ? $clog2(MAX_SIG) : 1;
    localparam int LW = $clog2(MAX_SIG + 1);

    logic [SIG_REGS-1:0][63:0] sig_pair_reg;
    logic [3:0]                sig_len_reg;
    logic [CNT_W-1:0]          hit_cap_reg;

    logic [SIG_WORDS-1:0][31:0] sig_words;
    logic [LW-1:0]              len_eff;

    logic       q_valid, q_pop;
    word_item_t q_item;
    logic          req_valid, rsp_valid, rsp_match;
    logic [KW-1:0] req_tag, rsp_tag;
    logic [31:0]   req_a, req_b;

    assign cfg_ready = 1'b1;
    assign sig_words = sig_pair_reg;

    always_comb
    begin
        if (sig_len_reg == 4'd0)
        begin
            len_eff = LW'(1);
        end
        else if (int'(sig_len_reg) > MAX_SIG)
        begin
            len_eff = LW'(MAX_SIG);
        end
        else
        begin
            len_eff = LW'(sig_len_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_pair_reg <= '0;
            sig_len_reg  <= 4'd1;
            hit_cap_reg  <= DEFAULT_CAP;
        end
        else if (cfg_valid)
        begin
            if (cfg_index < CFG_IDX_W'(SIG_REGS))
            begin
                sig_pair_reg[cfg_index[2:0]] <= cfg_data;
            end
            else if (cfg_index == CFG_SIG_LEN)
            begin
                sig_len_reg <= cfg_data[3:0];
            end
            else if (cfg_index == CFG_HIT_CAP)
            begin
                hit_cap_reg <= cfg_data[CNT_W-1:0];
            end
        end
    end

    tfss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .word_item  (word_item),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    tfss_cmp #(
        .TAG_W (KW)
    ) u_cmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_tag   (req_tag),
        .req_a     (req_a),
        .req_b     (req_b),
        .rsp_valid (rsp_valid),
        .rsp_tag   (rsp_tag),
        .rsp_match (rsp_match)
    );

    tfss_back #(
        .MAX_SIG (MAX_SIG),
        .KW      (KW),
        .LW      (LW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .sig_words (sig_words),
        .sig_len   (len_eff),
        .hit_cap   (hit_cap_reg),
        .req_valid (req_valid),
        .req_tag   (req_tag),
        .req_a     (req_a),
        .req_b     (req_b),
        .rsp_valid (rsp_valid),
        .rsp_tag   (rsp_tag),
        .rsp_match (rsp_match),
        .hit_valid (hit_valid),
        .hit_stall (hit_stall),
        .hit_item  (hit_item)
    );

endmodule
`default_nettype wire
